// ----- design/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in a cycle -> consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/sdt_pkg.sv -----
// Package for the spring-damper tracker: constants, op codes, clip helper.
`default_nettype none
package sdt_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int GAIN_FRAC      = 16;
	localparam int DT_FRAC        = 16;
	localparam int HALF_DT_SHIFT  = 17;
	localparam int CLIP_W         = 68;
	localparam int MUL_W          = 33;
	localparam int PROD_W         = 2 * MUL_W;

	localparam logic [23:0] KP1_RST = 24'd1310720;
	localparam logic [23:0] KP2_RST = 24'd32768;
	localparam logic [23:0] KV1_RST = 24'd327680;
	localparam logic [23:0] KV2_RST = 24'd21627;

	localparam logic [1:0] REG_KP1 = 2'd0;
	localparam logic [1:0] REG_KP2 = 2'd1;
	localparam logic [1:0] REG_KV1 = 2'd2;
	localparam logic [1:0] REG_KV2 = 2'd3;

	// multiplier micro-ops, in issue order
	localparam logic [4:0] OP_EXX  = 5'd0;
	localparam logic [4:0] OP_EYY  = 5'd1;
	localparam logic [4:0] OP_DXX  = 5'd2;
	localparam logic [4:0] OP_DYY  = 5'd3;
	localparam logic [4:0] OP_DTDT = 5'd4;
	localparam logic [4:0] OP_QEX  = 5'd5;
	localparam logic [4:0] OP_QEY  = 5'd6;
	localparam logic [4:0] OP_QDX  = 5'd7;
	localparam logic [4:0] OP_QDY  = 5'd8;
	localparam logic [4:0] OP_KP1X = 5'd9;
	localparam logic [4:0] OP_KP1Y = 5'd10;
	localparam logic [4:0] OP_KV1X = 5'd11;
	localparam logic [4:0] OP_KV1Y = 5'd12;
	localparam logic [4:0] OP_KP2X = 5'd13;
	localparam logic [4:0] OP_KP2Y = 5'd14;
	localparam logic [4:0] OP_KV2X = 5'd15;
	localparam logic [4:0] OP_KV2Y = 5'd16;
	localparam logic [4:0] OP_VXDT = 5'd17;
	localparam logic [4:0] OP_VYDT = 5'd18;
	localparam logic [4:0] OP_AXH  = 5'd19;
	localparam logic [4:0] OP_AYH  = 5'd20;
	localparam logic [4:0] OP_AXDT = 5'd21;
	localparam logic [4:0] OP_AYDT = 5'd22;

	localparam logic [4:0] SQ_LAST_STEP  = 5'd5;
	localparam logic [4:0] MAC_LAST_STEP = 5'd18;

	typedef struct packed {
		logic signed [31:0] val;
		logic               sat;
	} clip_t;

	function automatic clip_t clip32(input logic signed [CLIP_W-1:0] x);
		clip_t r;
		if (x > CLIP_W'(signed'(32'h7fffffff))) begin
			r.val = 32'sh7fffffff;
			r.sat = 1'b1;
		end else if (x < CLIP_W'(signed'(32'h80000000))) begin
			r.val = 32'sh80000000;
			r.sat = 1'b1;
		end else begin
			r.val = x[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/sdt_mul.sv -----
// Shared signed multiplier with registered product.
`default_nettype none
module sdt_mul
	import sdt_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic signed [MUL_W-1:0]  a,
	input  wire logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0]      prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule
`default_nettype wire

// ----- design/sdt_sqrt.sv -----
// Bit-serial restoring square root, one result bit per cycle.
`default_nettype none
module sdt_sqrt
	import sdt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             busy,
	output logic             done,
	output logic [31:0]      root
);

	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic        ge;

	assign rem_sh = {rem_q, rad_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ----- design/spring_damper_tracker_2d.sv -----
// Top level of the 2D nonlinear spring-damper tracker.
//
//  channel   dir  handshake          payload
//  cfg       in   cfg_we             cfg_index (0..3 gain), cfg_data (Q8.16)
//  s_*       in   s_tvalid/s_tready  target x/y, target vx/vy, time step
//  m_*       out  m_tvalid/m_tready  position x/y, velocity x/y, saturated
//
// Each transaction runs from acceptance through an error step, the squares,
// two square-root passes, the multiply-accumulate run through the one shared
// 33x33 multiplier, a commit and a return to idle before the next s_tready.
// The result is written to the output register at the commit. s_tready is
// high only when the sequencer is idle; a finished result sits in the output
// register and the next item is taken meanwhile. The final commit waits only
// if the previous result has not been taken yet.
// Reset puts the state at zero and the gains at their defaults.
`default_nettype none
module spring_damper_tracker_2d
	import sdt_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [23:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// target_x, target_y, target_vx, target_vy, time_step
	input  wire logic [143:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// pos_x, pos_y, vel_x, vel_y, saturated, 7 zero bits
	output logic [135:0]      m_tdata
);

	`include "assert_macros.svh"

	localparam int ACC_W = 44;
	localparam int NP_W  = 36;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ERR  = 3'd1;
	localparam logic [2:0] ST_SQ   = 3'd2;
	localparam logic [2:0] ST_RTE  = 3'd3;
	localparam logic [2:0] ST_RTD  = 3'd4;
	localparam logic [2:0] ST_MAC  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0] state_q;
	logic [4:0] step_q;

	// gains
	logic [23:0] kp1_q, kp2_q, kv1_q, kv2_q;

	// tracked state
	logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;

	// per-item working registers
	logic signed [31:0] tx_q, ty_q, tvx_q, tvy_q;
	logic [15:0]        dt_q;
	logic signed [31:0] ex_q, ey_q, dx_q, dy_q;
	logic [63:0]        sume_q, sumd_q;
	logic signed [31:0] elen_q, dlen_q;
	logic [15:0]        h_q;
	logic signed [31:0] qex_q, qey_q, qdx_q, qdy_q;
	logic signed [ACC_W-1:0] accx_q, accy_q;
	logic signed [NP_W-1:0]  npx_q, npy_q, nvx_q, nvy_q;
	logic               sat_q;

	// output register
	logic         out_valid_q;
	logic [135:0] out_data_q;

	// shared units
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_s1;
	logic        sq_start, sq_busy, sq_done;
	logic [63:0] sq_rad;
	logic [31:0] sq_root;

	sdt_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	sdt_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.busy     (sq_busy),
		.done     (sq_done),
		.root     (sq_root)
	);

	// sequencer op numbering: squares first, then the MAC run
	logic [4:0] op_issue, op_done;
	logic       proc_en;

	assign op_issue = (state_q == ST_MAC) ? 5'(step_q + OP_QEX) : step_q;
	assign op_done  = 5'(op_issue - 5'd1);
	assign proc_en  = ((state_q == ST_SQ) || (state_q == ST_MAC)) && (step_q != 5'd0);

	// error terms, clipped
	clip_t ex_c, ey_c, dx_c, dy_c;
	assign ex_c = clip32(CLIP_W'(33'(tx_q) - 33'(pos_x_q)));
	assign ey_c = clip32(CLIP_W'(33'(ty_q) - 33'(pos_y_q)));
	assign dx_c = clip32(CLIP_W'(33'(tvx_q) - 33'(vel_x_q)));
	assign dy_c = clip32(CLIP_W'(33'(tvy_q) - 33'(vel_y_q)));

	// root, quadratic-term and acceleration clips
	clip_t root_c, q_c, ax_c, ay_c;
	assign root_c = clip32(CLIP_W'({1'b0, sq_root}));
	assign q_c    = clip32(CLIP_W'(prod_s1 >>> FRAC_BITS));
	assign ax_c   = clip32(CLIP_W'(accx_q));
	assign ay_c   = clip32(CLIP_W'(accy_q));

	// final clips
	clip_t npx_c, npy_c, nvx_c, nvy_c;
	assign npx_c = clip32(CLIP_W'(npx_q));
	assign npy_c = clip32(CLIP_W'(npy_q));
	assign nvx_c = clip32(CLIP_W'(nvx_q));
	assign nvy_c = clip32(CLIP_W'(nvy_q));

	logic commit;
	logic sat_final;
	assign commit    = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	assign sat_final = sat_q | npx_c.sat | npy_c.sat | nvx_c.sat | nvy_c.sat;

	// sqrt launches: e at the end of squares, d right after e finishes
	assign sq_start = ((state_q == ST_SQ) && (step_q == SQ_LAST_STEP)) ||
	                  ((state_q == ST_RTE) && sq_done);
	assign sq_rad   = (state_q == ST_SQ) ? sume_q : sumd_q;

	// operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_issue)
			OP_EXX:  begin mul_a = MUL_W'(ex_q);  mul_b = MUL_W'(ex_q);   end
			OP_EYY:  begin mul_a = MUL_W'(ey_q);  mul_b = MUL_W'(ey_q);   end
			OP_DXX:  begin mul_a = MUL_W'(dx_q);  mul_b = MUL_W'(dx_q);   end
			OP_DYY:  begin mul_a = MUL_W'(dy_q);  mul_b = MUL_W'(dy_q);   end
			OP_DTDT: begin mul_a = MUL_W'(dt_q);  mul_b = MUL_W'(dt_q);   end
			OP_QEX:  begin mul_a = MUL_W'(ex_q);  mul_b = MUL_W'(elen_q); end
			OP_QEY:  begin mul_a = MUL_W'(ey_q);  mul_b = MUL_W'(elen_q); end
			OP_QDX:  begin mul_a = MUL_W'(dx_q);  mul_b = MUL_W'(dlen_q); end
			OP_QDY:  begin mul_a = MUL_W'(dy_q);  mul_b = MUL_W'(dlen_q); end
			OP_KP1X: begin mul_a = MUL_W'(ex_q);  mul_b = MUL_W'(kp1_q);  end
			OP_KP1Y: begin mul_a = MUL_W'(ey_q);  mul_b = MUL_W'(kp1_q);  end
			OP_KV1X: begin mul_a = MUL_W'(dx_q);  mul_b = MUL_W'(kv1_q);  end
			OP_KV1Y: begin mul_a = MUL_W'(dy_q);  mul_b = MUL_W'(kv1_q);  end
			OP_KP2X: begin mul_a = MUL_W'(qex_q); mul_b = MUL_W'(kp2_q);  end
			OP_KP2Y: begin mul_a = MUL_W'(qey_q); mul_b = MUL_W'(kp2_q);  end
			OP_KV2X: begin mul_a = MUL_W'(qdx_q); mul_b = MUL_W'(kv2_q);  end
			OP_KV2Y: begin mul_a = MUL_W'(qdy_q); mul_b = MUL_W'(kv2_q);  end
			OP_VXDT: begin mul_a = MUL_W'(vel_x_q); mul_b = MUL_W'(dt_q); end
			OP_VYDT: begin mul_a = MUL_W'(vel_y_q); mul_b = MUL_W'(dt_q); end
			OP_AXH:  begin mul_a = MUL_W'(ax_c.val); mul_b = MUL_W'(h_q); end
			OP_AYH:  begin mul_a = MUL_W'(ay_c.val); mul_b = MUL_W'(h_q); end
			OP_AXDT: begin mul_a = MUL_W'(ax_c.val); mul_b = MUL_W'(dt_q); end
			OP_AYDT: begin mul_a = MUL_W'(ay_c.val); mul_b = MUL_W'(dt_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			kp1_q       <= KP1_RST;
			kp2_q       <= KP2_RST;
			kv1_q       <= KV1_RST;
			kv2_q       <= KV2_RST;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KP1: kp1_q <= cfg_data;
					REG_KP2: kp2_q <= cfg_data;
					REG_KV1: kv1_q <= cfg_data;
					REG_KV2: kv2_q <= cfg_data;
					default: ;
				endcase
			end
			// a commit refills the output register in the cycle it drains
			if (commit) out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_tvalid) state_q <= ST_ERR;
				ST_ERR: begin
					state_q <= ST_SQ;
					step_q  <= '0;
				end
				ST_SQ: begin
					if (step_q == SQ_LAST_STEP) state_q <= ST_RTE;
					else step_q <= step_q + 5'd1;
				end
				ST_RTE: if (sq_done) state_q <= ST_RTD;
				ST_RTD: if (sq_done) begin
					state_q <= ST_MAC;
					step_q  <= '0;
				end
				ST_MAC: begin
					if (step_q == MAC_LAST_STEP) state_q <= ST_DONE;
					else step_q <= step_q + 5'd1;
				end
				ST_DONE: if (commit) begin
					state_q     <= ST_IDLE;
					pos_x_q     <= npx_c.val;
					pos_y_q     <= npy_c.val;
					vel_x_q     <= nvx_c.val;
					vel_y_q     <= nvy_c.val;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			tx_q  <= s_tdata[31:0];
			ty_q  <= s_tdata[63:32];
			tvx_q <= s_tdata[95:64];
			tvy_q <= s_tdata[127:96];
			dt_q  <= s_tdata[143:128];
		end
		if (state_q == ST_ERR) begin
			ex_q   <= ex_c.val;
			ey_q   <= ey_c.val;
			dx_q   <= dx_c.val;
			dy_q   <= dy_c.val;
			sat_q  <= ex_c.sat | ey_c.sat | dx_c.sat | dy_c.sat;
			sume_q <= '0;
			sumd_q <= '0;
			accx_q <= '0;
			accy_q <= '0;
			npx_q  <= NP_W'(pos_x_q);
			npy_q  <= NP_W'(pos_y_q);
			nvx_q  <= NP_W'(vel_x_q);
			nvy_q  <= NP_W'(vel_y_q);
		end
		if ((state_q == ST_RTE) && sq_done) begin
			elen_q <= root_c.val;
			if (root_c.sat) sat_q <= 1'b1;
		end
		if ((state_q == ST_RTD) && sq_done) begin
			dlen_q <= root_c.val;
			if (root_c.sat) sat_q <= 1'b1;
		end
		// acceleration clip counted once per axis, when first used
		if (state_q == ST_MAC && op_issue == OP_AXH && ax_c.sat) sat_q <= 1'b1;
		if (state_q == ST_MAC && op_issue == OP_AYH && ay_c.sat) sat_q <= 1'b1;
		if (proc_en) begin
			case (op_done)
				OP_EXX, OP_EYY: sume_q <= sume_q + prod_s1[63:0];
				OP_DXX, OP_DYY: sumd_q <= sumd_q + prod_s1[63:0];
				OP_DTDT: h_q <= prod_s1[HALF_DT_SHIFT+15:HALF_DT_SHIFT];
				OP_QEX: begin qex_q <= q_c.val; if (q_c.sat) sat_q <= 1'b1; end
				OP_QEY: begin qey_q <= q_c.val; if (q_c.sat) sat_q <= 1'b1; end
				OP_QDX: begin qdx_q <= q_c.val; if (q_c.sat) sat_q <= 1'b1; end
				OP_QDY: begin qdy_q <= q_c.val; if (q_c.sat) sat_q <= 1'b1; end
				OP_KP1X, OP_KV1X, OP_KP2X, OP_KV2X:
					accx_q <= accx_q + ACC_W'(prod_s1 >>> GAIN_FRAC);
				OP_KP1Y, OP_KV1Y, OP_KP2Y, OP_KV2Y:
					accy_q <= accy_q + ACC_W'(prod_s1 >>> GAIN_FRAC);
				OP_VXDT, OP_AXH: npx_q <= npx_q + NP_W'(prod_s1 >>> DT_FRAC);
				OP_VYDT, OP_AYH: npy_q <= npy_q + NP_W'(prod_s1 >>> DT_FRAC);
				OP_AXDT: nvx_q <= nvx_q + NP_W'(prod_s1 >>> DT_FRAC);
				OP_AYDT: nvy_q <= nvy_q + NP_W'(prod_s1 >>> DT_FRAC);
				default: ;
			endcase
		end
		if (commit) begin
			out_data_q <= {7'b0, sat_final, nvy_c.val, nvx_c.val, npy_c.val, npx_c.val};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`ASSERT_IMPLIES(a_sqrt_in_root, clk, arst_n, sq_busy,
		(state_q == ST_RTE) || (state_q == ST_RTD))
	`ASSERT_NEXT(a_accept_to_err, clk, arst_n, s_tvalid && s_tready, state_q == ST_ERR)
	`ASSERT_IMPLIES(a_mac_step_bound, clk, arst_n, state_q == ST_MAC,
		step_q <= MAC_LAST_STEP)
	`ASSERT_IMPLIES(a_commit_room, clk, arst_n, commit, !out_valid_q || m_tready)

endmodule
`default_nettype wire
